### hdl/tcl_pkg.sv
// Shared types, widths and codes of the triggered capture logger.
`timescale 1ns / 1ps
package tcl_pkg;

  // Build-time defaults handed to the top level
  localparam int unsigned BUFFER_DEPTH_DEF = 1024;
  localparam int unsigned CHANNELS_DEF     = 8;
  localparam int unsigned SAMPLE_BITS_DEF  = 16;

  // Fixed field widths
  localparam int unsigned IN_SAMPLE_W = 16;
  localparam int unsigned MAX_CHAN    = 8;
  localparam int unsigned ADDR_OUT_W  = 10;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned PHASE_W     = 2;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned RLEN_W      = 11;

  // Run mode codes; codes five to seven run like normal mode
  localparam logic [MODE_W-1:0] MD_CONT   = 3'd0;
  localparam logic [MODE_W-1:0] MD_AUTO   = 3'd1;
  localparam logic [MODE_W-1:0] MD_NORMAL = 3'd2;
  localparam logic [MODE_W-1:0] MD_SINGLE = 3'd3;
  localparam logic [MODE_W-1:0] MD_STOP   = 3'd4;

  // Register reset values
  localparam logic [MODE_W-1:0] MODE_RST    = MD_AUTO;
  localparam logic [CNT_W-1:0]  DECIM_RST   = 16'd1;
  localparam logic [RLEN_W-1:0] RLEN_RST    = 11'd1024;
  localparam logic [CNT_W-1:0]  TIMEOUT_RST = 16'd1024;
  localparam logic [CNT_W-1:0]  HOLDOFF_RST = 16'd1024;

  typedef struct packed {
    logic signed [IN_SAMPLE_W-1:0] chan0_sample;
    logic signed [IN_SAMPLE_W-1:0] chan1_sample;
    logic signed [IN_SAMPLE_W-1:0] chan2_sample;
    logic signed [IN_SAMPLE_W-1:0] chan3_sample;
    logic signed [IN_SAMPLE_W-1:0] chan4_sample;
    logic signed [IN_SAMPLE_W-1:0] chan5_sample;
    logic signed [IN_SAMPLE_W-1:0] chan6_sample;
    logic signed [IN_SAMPLE_W-1:0] chan7_sample;
    logic signed [IN_SAMPLE_W-1:0] trigger_sample;
    logic                          soft_trigger_pulse;
  } smp_item_t;

  typedef struct packed {
    logic                  sample_stored;
    logic [ADDR_OUT_W-1:0] store_address;
    logic                  record_done;
    logic [PHASE_W-1:0]    capture_phase;
    logic [MODE_W-1:0]     current_mode;
  } res_item_t;

endpackage

### hdl/tcl_smp_if.sv
// Sample set channel: valid/ready handshake with the input item payload.
`timescale 1ns / 1ps
interface tcl_smp_if;
  logic               valid;
  logic               ready;
  tcl_pkg::smp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/tcl_res_if.sv
// Result channel: valid/ready handshake with the per-tick status payload.
`timescale 1ns / 1ps
interface tcl_res_if;
  logic               valid;
  logic               ready;
  tcl_pkg::res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/tcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/triggered_capture_logger_unit.sv
// Triggered capture logger: trigger phase machine, sample buffers and APB registers.
`timescale 1ns / 1ps
// Takes one sample set per clock while smp_i.ready is high and returns one status
// transfer per set. The whole tick (trigger compares, the Wait/Ready/Store/Holdoff
// walk, the counter steps and the buffer write) is evaluated in the cycle the set is
// accepted, straight from the state registers, and the status is registered into a
// two-entry output buffer: out_q, which drives the result port, or skid_q when out_q
// holds a result not yet taken. smp_i.ready drops only when both buffer entries hold
// results that the sink has not taken. Samples go into CHANNELS RAMs of BUFFER_DEPTH
// words of SAMPLE_BITS bits, one word per channel per stored set; the buffer
// is never read back here, so it has no clearing pass after reset.
// Registers (APB, 32-bit, byte address 4*i): 0 mode_setting (a write also
// reloads the run mode), 1 slope_select, 2 trigger_level, 3 decimation,
// 4 record_length, 5 auto_timeout, 6 holdoff_ticks. Write them only while
// no result is outstanding.
module triggered_capture_logger_unit #(
  parameter int unsigned BUFFER_DEPTH = tcl_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned CHANNELS     = tcl_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS  = tcl_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcl_smp_if.sink     smp_i,
  tcl_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW   = $clog2(BUFFER_DEPTH);
  localparam int unsigned LW   = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CMPW = (LW > tcl_pkg::RLEN_W) ? LW : tcl_pkg::RLEN_W;
  localparam int unsigned CW   = tcl_pkg::CNT_W;

  // Register map indexes (paddr[4:2])
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_SLOPE   = 3'd1;
  localparam logic [2:0] REG_LEVEL   = 3'd2;
  localparam logic [2:0] REG_DECIM   = 3'd3;
  localparam logic [2:0] REG_RLEN    = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;
  localparam logic [2:0] REG_HOLDOFF = 3'd6;

  typedef enum logic [tcl_pkg::PHASE_W-1:0] {
    PH_WAIT,
    PH_READY,
    PH_STORE,
    PH_HOLDOFF
  } phase_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [tcl_pkg::MODE_W-1:0]        mode_setting_q;
  logic                              slope_q;
  logic signed [tcl_pkg::IN_SAMPLE_W-1:0] level_q;
  logic [CW-1:0]                     decim_q;
  logic [tcl_pkg::RLEN_W-1:0]        rlen_q;
  logic [CW-1:0]                     timeout_q;
  logic [CW-1:0]                     holdoff_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MODE:    prdata = 32'(mode_setting_q);
      REG_SLOPE:   prdata = 32'(slope_q);
      REG_LEVEL:   prdata = 32'(unsigned'(level_q));
      REG_DECIM:   prdata = 32'(decim_q);
      REG_RLEN:    prdata = 32'(rlen_q);
      REG_TIMEOUT: prdata = 32'(timeout_q);
      REG_HOLDOFF: prdata = 32'(holdoff_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tick state
  // ---------------------------------------------------------------------------
  logic [tcl_pkg::MODE_W-1:0] run_mode_q, run_mode_d;
  phase_e                     phase_q, phase_d;
  logic [CW-1:0]              dec_cnt_q, dec_cnt_d;
  logic [AW-1:0]              widx_q, widx_d;
  logic [CW-1:0]              tmo_cnt_q, tmo_cnt_d;
  logic [CW-1:0]              hold_cnt_q, hold_cnt_d;
  logic                       pend_q, pend_d;

  logic push, pop;
  logic set_we;
  tcl_pkg::res_item_t res_d;

  // Output buffer: out_q drives the port, skid_q catches a stalled transfer
  tcl_pkg::res_item_t out_q, skid_q;
  logic               out_vld_q, skid_vld_q;

  assign smp_i.ready = !skid_vld_q;
  assign push        = smp_i.valid && smp_i.ready;
  assign pop         = out_vld_q && res_o.ready;
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  logic signed [tcl_pkg::IN_SAMPLE_W-1:0] trig_s;
  assign trig_s = smp_i.data.trigger_sample;

  // Record length as used: zero or too large means the full buffer
  logic [CMPW-1:0] rlen_ext, rlen_eff, nxt_idx;
  logic            rec_end;
  assign rlen_ext = CMPW'(rlen_q);
  assign rlen_eff = (rlen_ext == '0 || rlen_ext > CMPW'(BUFFER_DEPTH))
                    ? CMPW'(BUFFER_DEPTH) : rlen_ext;
  assign nxt_idx  = CMPW'(widx_q) + CMPW'(1);
  assign rec_end  = (nxt_idx >= rlen_eff);

  always_comb begin
    logic [CW:0] dsum;
    logic        arm;
    logic        fire;

    run_mode_d = run_mode_q;
    phase_d    = phase_q;
    dec_cnt_d  = dec_cnt_q;
    widx_d     = widx_q;
    tmo_cnt_d  = tmo_cnt_q;
    hold_cnt_d = hold_cnt_q;
    pend_d     = pend_q | smp_i.data.soft_trigger_pulse;
    set_we     = 1'b0;
    res_d      = '0;

    dsum = {1'b0, dec_cnt_q} + {{CW{1'b0}}, 1'b1};
    arm  = slope_q ? (trig_s > level_q) : (trig_s < level_q);
    fire = slope_q ? (trig_s <= level_q) : (trig_s >= level_q);

    if (run_mode_q == tcl_pkg::MD_CONT) begin
      // Plain decimated ring, no trigger
      if (dec_cnt_q == '0) begin
        set_we = 1'b1;
        res_d.sample_stored = 1'b1;
        res_d.store_address = tcl_pkg::ADDR_OUT_W'(widx_q);
        widx_d = rec_end ? '0 : AW'(nxt_idx);
      end
      dec_cnt_d = (dsum >= {1'b0, decim_q}) ? '0 : dsum[CW-1:0];
    end else begin
      // Phases run in order; a phase entered earlier this tick also runs
      if (phase_d == PH_WAIT) begin
        if (run_mode_q == tcl_pkg::MD_STOP) begin
          if (pend_d) begin
            phase_d    = PH_READY;
            run_mode_d = tcl_pkg::MD_SINGLE;
          end
        end else begin
          if (run_mode_d == tcl_pkg::MD_AUTO) begin
            tmo_cnt_d = tmo_cnt_d + CW'(1);
            if (tmo_cnt_d == timeout_q) begin
              phase_d   = PH_STORE;
              tmo_cnt_d = '0;
            end
          end
          // arming beats the timeout in the same tick
          if (arm || pend_d) begin
            phase_d = PH_READY;
          end
        end
      end
      if (phase_d == PH_READY) begin
        if (run_mode_d == tcl_pkg::MD_AUTO) begin
          tmo_cnt_d = tmo_cnt_d + CW'(1);
          if (tmo_cnt_d == timeout_q) begin
            phase_d   = PH_STORE;
            tmo_cnt_d = '0;
          end
        end
        if (fire || pend_d) begin
          phase_d   = PH_STORE;
          tmo_cnt_d = '0;
        end
        if (pend_d) begin
          pend_d = 1'b0;
        end
      end
      if (phase_d == PH_STORE) begin
        if (dec_cnt_q == '0) begin
          set_we = 1'b1;
          res_d.sample_stored = 1'b1;
          res_d.store_address = tcl_pkg::ADDR_OUT_W'(widx_q);
          widx_d = rec_end ? '0 : AW'(nxt_idx);
          if (rec_end) begin
            res_d.record_done = 1'b1;
            if (run_mode_d != tcl_pkg::MD_SINGLE) begin
              phase_d    = PH_HOLDOFF;
              hold_cnt_d = '0;
            end else begin
              run_mode_d = tcl_pkg::MD_STOP;
              phase_d    = PH_WAIT;
            end
          end
        end
        // the decimation count is zero on entry whenever a store happened
        dec_cnt_d = (dsum >= {1'b0, decim_q}) ? '0 : dsum[CW-1:0];
      end
      if (phase_d == PH_HOLDOFF) begin
        hold_cnt_d = hold_cnt_d + CW'(1);
        if (hold_cnt_d == holdoff_q) begin
          phase_d = PH_WAIT;
        end
      end
    end

    res_d.capture_phase = phase_d;
    res_d.current_mode  = run_mode_d;
  end

  // ---------------------------------------------------------------------------
  // State, configuration and output buffer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_setting_q <= tcl_pkg::MODE_RST;
      slope_q        <= 1'b0;
      level_q        <= '0;
      decim_q        <= tcl_pkg::DECIM_RST;
      rlen_q         <= tcl_pkg::RLEN_RST;
      timeout_q      <= tcl_pkg::TIMEOUT_RST;
      holdoff_q      <= tcl_pkg::HOLDOFF_RST;
      run_mode_q     <= tcl_pkg::MODE_RST;
      phase_q        <= PH_WAIT;
      dec_cnt_q      <= '0;
      widx_q         <= '0;
      tmo_cnt_q      <= '0;
      hold_cnt_q     <= '0;
      pend_q         <= 1'b0;
      out_vld_q      <= 1'b0;
      skid_vld_q     <= 1'b0;
    end else begin
      if (push) begin
        phase_q    <= phase_d;
        dec_cnt_q  <= dec_cnt_d;
        widx_q     <= widx_d;
        tmo_cnt_q  <= tmo_cnt_d;
        hold_cnt_q <= hold_cnt_d;
        pend_q     <= pend_d;
      end
      // a mode write reloads the run mode and takes priority over a tick
      if (cfg_wr && cfg_idx == REG_MODE) begin
        run_mode_q <= pwdata[tcl_pkg::MODE_W-1:0];
      end else if (push) begin
        run_mode_q <= run_mode_d;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_MODE:    mode_setting_q <= pwdata[tcl_pkg::MODE_W-1:0];
          REG_SLOPE:   slope_q   <= pwdata[0];
          REG_LEVEL:   level_q   <= signed'(pwdata[tcl_pkg::IN_SAMPLE_W-1:0]);
          REG_DECIM:   decim_q   <= pwdata[CW-1:0];
          REG_RLEN:    rlen_q    <= pwdata[tcl_pkg::RLEN_W-1:0];
          REG_TIMEOUT: timeout_q <= pwdata[CW-1:0];
          REG_HOLDOFF: holdoff_q <= pwdata[CW-1:0];
          default: ;
        endcase
      end
      // two-entry output buffer
      if (pop) begin
        if (skid_vld_q) begin
          out_q <= skid_q;
          if (push) begin
            skid_q <= res_d;
          end else begin
            skid_vld_q <= 1'b0;
          end
        end else if (push) begin
          out_q <= res_d;
        end else begin
          out_vld_q <= 1'b0;
        end
      end else if (push) begin
        if (!out_vld_q) begin
          out_q     <= res_d;
          out_vld_q <= 1'b1;
        end else begin
          skid_q     <= res_d;
          skid_vld_q <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample buffers, one RAM per channel
  // ---------------------------------------------------------------------------
  logic signed [tcl_pkg::IN_SAMPLE_W-1:0] chan_s [tcl_pkg::MAX_CHAN];
  assign chan_s[0] = smp_i.data.chan0_sample;
  assign chan_s[1] = smp_i.data.chan1_sample;
  assign chan_s[2] = smp_i.data.chan2_sample;
  assign chan_s[3] = smp_i.data.chan3_sample;
  assign chan_s[4] = smp_i.data.chan4_sample;
  assign chan_s[5] = smp_i.data.chan5_sample;
  assign chan_s[6] = smp_i.data.chan6_sample;
  assign chan_s[7] = smp_i.data.chan7_sample;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic [SAMPLE_BITS-1:0] wdata;
    // sign-extend (or trim) to the stored width
    assign wdata = SAMPLE_BITS'(chan_s[c]);

    tcl_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(BUFFER_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (push && set_we),
      .waddr_i(widx_q),
      .wdata_i(wdata),
      .raddr_i(widx_q),
      .rdata_o()
    );
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without a head entry");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !out_vld_q) |=> out_vld_q)
    else $error("accepted set produced no result");

  a_done_stores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.record_done) |-> res_o.data.sample_stored)
    else $error("record end reported without a store");

  a_cont_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.current_mode == tcl_pkg::MD_CONT)
      |-> !res_o.data.record_done)
    else $error("record end reported in continuous mode");

  a_addr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.data.sample_stored) |-> (res_o.data.store_address == '0))
    else $error("address reported without a store");

endmodule
